// File: design/txrf_pkg.sv
// ----------------------------------------------------------------------------
// txrf_pkg: shared types for the transmit ring FIFO
// Word types of the request and response channels, the kind codes and the
// default ring depth.
// ----------------------------------------------------------------------------
package txrf_pkg;

   localparam int unsigned DEPTH_DEFAULT = 256;

   // kind codes of a request word
   localparam logic KIND_WRITE = 1'b0;   // store one byte
   localparam logic KIND_READY = 1'b1;   // transmitter wants a byte

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       last_of_write;
      logic       cts_high;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       dropped_oldest;
      logic       write_overflowed;
      logic [7:0] fill_level;
   } rsp_type;

endpackage

// File: design/tx_ring_fifo_drop_oldest_cts.sv
// ----------------------------------------------------------------------------
// tx_ring_fifo_drop_oldest_cts: transmit ring FIFO with overwrite of oldest
// Byte ring buffer in front of a serial transmitter, with clear-to-send flow
// control and a per-burst overrun flag.
// ----------------------------------------------------------------------------
// A request word is taken whenever start is high; busy never rises, so one
// word can go in every clock. Its response word passes the input register
// and then the result register, which drives it on rsp. It is strobed by
// rsp_valid for a single cycle: there is no back-pressure, so the receiver
// must take it then. A write stores data_byte at the head;
// when the head catches the tail the oldest byte is discarded, so at most
// DEPTH-1 bytes wait. A ready word pops the tail byte unless the ring is
// empty or flow control is on and cts_high is set. The byte store is a
// single-port-write, single-port-read memory with a registered read; its
// contents are not cleared at reset, only the pointers, the burst flag and
// the valid bits are. flow_control_on resets to 1 and is written over the csr
// channel, which is always ready; it should only be changed while no word is in flight.
// ----------------------------------------------------------------------------
module tx_ring_fifo_drop_oldest_cts #(
   parameter int unsigned DEPTH = txrf_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  txrf_pkg::req_type req,
   // response channel
   output logic              rsp_valid,
   output txrf_pkg::rsp_type rsp,
   // control register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata
);
   import txrf_pkg::*;

   localparam int unsigned PTR_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W  = PTR_W + 1;
   localparam int unsigned FILL_W = (CNT_W > 8) ? CNT_W : 8;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   // --- control register
   logic flow_control_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_control_on_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         flow_control_on_ff <= csr_wdata;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // --- input register
   logic    req_valid_ff;
   req_type req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req;
      end
   end

   // --- ring pointers and burst flag
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             burst_dropped_ff, burst_dropped_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   logic             do_write, do_pop, held, dropped, overflowed;
   logic [PTR_W-1:0] wr_ptr_adv;
   logic [CNT_W-1:0] fill_cnt;
   logic [FILL_W-1:0] fill_ext;

   always_comb begin
      wr_ptr_in        = wr_ptr_ff;
      rd_ptr_in        = rd_ptr_ff;
      burst_dropped_in = burst_dropped_ff;
      dropped          = 1'b0;
      overflowed       = 1'b0;
      do_write         = req_valid_ff && (req_ff.kind == KIND_WRITE);
      held             = flow_control_on_ff && req_ff.cts_high;
      do_pop           = req_valid_ff && (req_ff.kind == KIND_READY)
                         && (wr_ptr_ff != rd_ptr_ff) && !held;
      wr_ptr_adv       = ptr_next(wr_ptr_ff);

      if (do_write) begin
         wr_ptr_in = wr_ptr_adv;
         // head caught the tail: throw the oldest byte away
         if (wr_ptr_adv == rd_ptr_ff) begin
            rd_ptr_in        = ptr_next(rd_ptr_ff);
            dropped          = 1'b1;
            burst_dropped_in = 1'b1;
         end
         if (req_ff.last_of_write) begin
            overflowed       = burst_dropped_in;
            burst_dropped_in = 1'b0;
         end
      end else if (do_pop) begin
         rd_ptr_in = ptr_next(rd_ptr_ff);
      end

      // occupancy after this word, wrapped at DEPTH
      if (wr_ptr_in >= rd_ptr_in) begin
         fill_cnt = CNT_W'(wr_ptr_in) - CNT_W'(rd_ptr_in);
      end else begin
         fill_cnt = CNT_W'(wr_ptr_in) + CNT_W'(DEPTH) - CNT_W'(rd_ptr_in);
      end
      fill_ext = FILL_W'(fill_cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         burst_dropped_ff <= 1'b0;
      end else begin
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         burst_dropped_ff <= burst_dropped_in;
      end
   end

   // --- byte store; read data lands in the result register
   logic [7:0] byte_store [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (do_write) begin
         byte_store[wr_ptr_ff] <= req_ff.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         rd_data_ff <= byte_store[rd_ptr_ff];
      end
   end

   // --- result register
   logic       rsp_valid_ff;
   logic       tx_valid_ff;
   logic       dropped_ff;
   logic       overflowed_ff;
   logic [7:0] fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         tx_valid_ff   <= do_pop;
         dropped_ff    <= dropped;
         overflowed_ff <= overflowed;
         fill_ff       <= fill_ext[7:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp.tx_valid         = tx_valid_ff;
   assign rsp.tx_byte          = tx_valid_ff ? rd_data_ff : 8'h00;
   assign rsp.dropped_oldest   = dropped_ff;
   assign rsp.write_overflowed = overflowed_ff;
   assign rsp.fill_level       = fill_ff;

endmodule

// File: design/txrf_checker.sv
// ----------------------------------------------------------------------------
// txrf_checker: port-level checks for the transmit ring FIFO
// Response timing and consistency of the response flags.
// ----------------------------------------------------------------------------
module txrf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input txrf_pkg::req_type req,
   input logic              rsp_valid,
   input txrf_pkg::rsp_type rsp
);
   import txrf_pkg::*;

   // every accepted word is answered after the input and result registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("txrf: accepted word got no response");

   // no response without a word taken in through the input and result registers
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("txrf: response without a word");

   // a word cannot both pop and drop
   a_pop_xor_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.tx_valid) |-> !rsp.dropped_oldest && !rsp.write_overflowed)
      else $error("txrf: pop word flagged a drop");

   // a drop on the last byte of a burst must be reported
   a_last_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.dropped_oldest && $past(req.last_of_write, 2))
      |-> rsp.write_overflowed)
      else $error("txrf: drop on last byte not reported");

endmodule

bind tx_ring_fifo_drop_oldest_cts txrf_checker u_txrf_checker (.*);

// File: tb/sv/tx_ring_fifo_drop_oldest_cts_tb.sv
// ----------------------------------------------------------------------------
// tx_ring_fifo_drop_oldest_cts_tb: self-checking bench for the transmit ring
// Drives write and ready words through the command port, keeps its own copy
// of the ring (head, tail, byte store, burst overrun flag, flow control) and
// checks every strobed response word, field by field, in order.
// ----------------------------------------------------------------------------
module tx_ring_fifo_drop_oldest_cts_tb;
   import txrf_pkg::*;

   localparam int unsigned RING_DEPTH     = DEPTH_DEFAULT;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned WATCHDOG_LIMIT = 2000;  // well above the longest idle gap
   localparam int unsigned REPORT_MAX     = 10;

   // what the sender does next: push a word, write the csr, or sit until
   // every owed response has come back
   typedef enum logic [1:0] {STEP_WORD, STEP_CSR, STEP_SETTLE} step_kind_type;

   typedef struct {
      step_kind_type what;
      req_type       word;
      logic          csr_value;
      int unsigned   idle;       // idle cycles in front of this step
   } stim_step_type;

   typedef enum logic [5:0] {
      DRV_FETCH = 6'b000001,
      DRV_GAP   = 6'b000010,
      DRV_ACT   = 6'b000100,
      DRV_WORD  = 6'b001000,
      DRV_CSR   = 6'b010000,
      DRV_DRAIN = 6'b100000
   } drv_state_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   logic    busy;
   req_type req       = '0;
   logic    rsp_valid;
   rsp_type rsp;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_wdata = 1'b0;

   tx_ring_fifo_drop_oldest_cts dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Ring predictor: own copy of the FIFO state
   // ------------------------------------------------------------------------
   logic [7:0]  ring_mem [RING_DEPTH];
   int unsigned head       = 0;
   int unsigned tail       = 0;
   logic        burst_lost = 1'b0;  // a byte of the open burst dropped data
   logic        flow_ctl   = 1'b1;  // matches the register's reset value

   int unsigned items_taken = 0, pops_seen = 0, drops_seen = 0;
   int unsigned overrun_reports = 0, held_count = 0, csr_writes = 0;
   int unsigned mismatches = 0;

   rsp_type     expected_rsp [$];
   int unsigned rsp_owed = 0;       // queue depth as seen at the last edge

   function automatic rsp_type ring_step(req_type w);
      rsp_type r;
      r = '0;
      if (w.kind == KIND_WRITE) begin
         ring_mem[head] = w.data_byte;
         head = (head + 1) % RING_DEPTH;
         // head caught the tail: oldest byte goes, tail steps on
         if (head == tail) begin
            tail = (tail + 1) % RING_DEPTH;
            r.dropped_oldest = 1'b1;
            burst_lost = 1'b1;
            drops_seen++;
         end
         if (w.last_of_write) begin
            r.write_overflowed = burst_lost;
            if (burst_lost) overrun_reports++;
            burst_lost = 1'b0;
         end
      end else if (head != tail && !(flow_ctl && w.cts_high)) begin
         r.tx_valid = 1'b1;
         r.tx_byte  = ring_mem[tail];
         tail = (tail + 1) % RING_DEPTH;
         pops_seen++;
      end else if (head != tail) begin
         held_count++;
      end
      r.fill_level = 8'((head + RING_DEPTH - tail) % RING_DEPTH);
      return r;
   endfunction

   task automatic note_fault(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t %s: exp v=%0b b=%02h drop=%0b ovf=%0b fill=%0d", $time, what,
                  want.tx_valid, want.tx_byte, want.dropped_oldest,
                  want.write_overflowed, want.fill_level);
      if (mismatches <= REPORT_MAX)
         $display("%0t %s: got v=%0b b=%02h drop=%0b ovf=%0b fill=%0d", $time, what,
                  got.tx_valid, got.tx_byte, got.dropped_oldest,
                  got.write_overflowed, got.fill_level);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------
   stim_step_type stim_steps [$];

   // mostly back-to-back, some short gaps, now and then a long one
   function automatic int unsigned pick_idle(bit quiet);
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_word(logic kind, logic [7:0] data, logic last, logic cts,
                             int unsigned idle);
      stim_step_type s;
      s.what = STEP_WORD;
      s.word.kind = kind;
      s.word.data_byte = data;
      s.word.last_of_write = last;
      s.word.cts_high = cts;
      s.csr_value = 1'b0;
      s.idle = idle;
      stim_steps.push_back(s);
   endtask

   task automatic queue_settle();
      stim_step_type s;
      s.what = STEP_SETTLE;
      s.word = '0;
      s.csr_value = 1'b0;
      s.idle = 0;
      stim_steps.push_back(s);
   endtask

   // csr only moves with the ring idle, so always settle first
   task automatic queue_csr(logic value);
      stim_step_type s;
      queue_settle();
      s.what = STEP_CSR;
      s.word = '0;
      s.csr_value = value;
      s.idle = pick_idle(1'b0);
      stim_steps.push_back(s);
   endtask

   // one write burst with ready words mixed in; mostly well-formed (last on
   // final byte), sometimes left open or with stray last marks
   task automatic queue_burst(int unsigned len, int unsigned ready_pct,
                              int unsigned cts_pct);
      bit quiet;
      bit broken;
      logic last;
      quiet  = ($urandom_range(0, 3) == 0);
      broken = ($urandom_range(0, 9) == 0);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < ready_pct)
            queue_word(KIND_READY, 8'($urandom), 1'($urandom),
                       $urandom_range(0, 99) < cts_pct, pick_idle(quiet));
         last = broken ? 1'($urandom) : (i == len - 1);
         queue_word(KIND_WRITE, 8'($urandom), last, 1'($urandom), pick_idle(quiet));
      end
   endtask

   // mixed traffic: bursts of writes against runs of ready words
   task automatic queue_mix(int unsigned n_words, int unsigned cts_pct);
      int unsigned made;
      int unsigned len;
      bit quiet;
      made = 0;
      while (made < n_words) begin
         len = $urandom_range(1, 5);
         if ($urandom_range(0, 1) == 0) begin
            queue_burst(len, 0, cts_pct);
         end else begin
            quiet = ($urandom_range(0, 3) == 0);
            for (int unsigned i = 0; i < len; i++)
               queue_word(KIND_READY, 8'($urandom), 1'($urandom),
                          $urandom_range(0, 99) < cts_pct, pick_idle(quiet));
         end
         made += len;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: changes inputs on the falling edge, one step at a time
   // ------------------------------------------------------------------------
   drv_state_type drv_state  = DRV_FETCH;
   stim_step_type cur;
   int unsigned   gap_left   = 0;
   int unsigned   settle_left = 0;
   logic          word_taken = 1'b0;   // set from the last rising edge
   logic          csr_taken  = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         // retire whatever the last rising edge took
         if (drv_state == DRV_WORD && word_taken) drv_state = DRV_FETCH;
         if (drv_state == DRV_CSR && csr_taken) drv_state = DRV_FETCH;
         // settle: hold off until nothing is owed, then SETTLE_CYCLES spare cycles
         if (drv_state == DRV_DRAIN) begin
            if (expected_rsp.size() != 0) settle_left = SETTLE_CYCLES;
            else if (settle_left != 0) settle_left--;
            else drv_state = DRV_FETCH;
         end
         if (drv_state == DRV_GAP) begin
            gap_left--;
            if (gap_left == 0) drv_state = DRV_ACT;
         end
         if (drv_state == DRV_FETCH && stim_steps.size() != 0) begin
            cur = stim_steps.pop_front();
            if (cur.idle != 0) begin
               gap_left = cur.idle;
               drv_state = DRV_GAP;
            end else begin
               drv_state = DRV_ACT;
            end
         end
         if (drv_state == DRV_ACT) begin
            case (cur.what)
               STEP_WORD: drv_state = DRV_WORD;
               STEP_CSR:  drv_state = DRV_CSR;
               default: begin
                  settle_left = SETTLE_CYCLES;
                  drv_state = DRV_DRAIN;
               end
            endcase
         end
         // single assignment per signal per edge: start stays high across
         // back-to-back words
         start <= (drv_state == DRV_WORD);
         if (drv_state == DRV_WORD) req <= cur.word;
         csr_valid <= (drv_state == DRV_CSR);
         if (drv_state == DRV_CSR) csr_wdata <= cur.csr_value;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: samples on the rising edge, predicts, checks, watchdog
   // ------------------------------------------------------------------------
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      rsp_type want;
      logic    took_word;
      logic    took_csr;
      if (reset) begin
         word_taken <= 1'b0;
         csr_taken  <= 1'b0;
         idle_cycles = 0;
      end else begin
         took_word = start && busy === 1'b0;
         took_csr  = csr_valid && csr_ready === 1'b1;
         // the response strobed now belongs to an earlier word, so check
         // before predicting the word taken at this edge
         if (rsp_valid === 1'b1) begin
            if (expected_rsp.size() == 0) begin
               note_fault("unexpected response", '0, rsp);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp.tx_valid !== want.tx_valid || rsp.tx_byte !== want.tx_byte ||
                   rsp.dropped_oldest !== want.dropped_oldest ||
                   rsp.write_overflowed !== want.write_overflowed ||
                   rsp.fill_level !== want.fill_level)
                  note_fault("response mismatch", want, rsp);
            end
         end else if (rsp_valid !== 1'b0) begin
            note_fault("rsp_valid unknown", '0, rsp);
         end
         if (took_word) begin
            expected_rsp.push_back(ring_step(req));
            items_taken++;
         end
         if (took_csr) begin
            flow_ctl = csr_wdata;
            csr_writes++;
         end
         word_taken <= took_word;
         csr_taken  <= took_csr;
         rsp_owed   <= expected_rsp.size();
         if (took_word || took_csr || rsp_valid === 1'b1) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no traffic for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      // directed: empty pop, held pop, extremes of data, last on a ready
      // word, two-byte bursts, then flow control off against a high cts
      queue_word(KIND_READY, 8'h00, 1'b0, 1'b0, 0);   // empty: nothing to send
      queue_word(KIND_WRITE, 8'h00, 1'b0, 1'b0, 0);
      queue_word(KIND_WRITE, 8'hFF, 1'b1, 1'b1, 0);
      queue_word(KIND_READY, 8'hFF, 1'b0, 1'b1, 0);   // held by cts
      queue_word(KIND_READY, 8'h00, 1'b1, 1'b0, 0);   // last ignored on ready
      queue_word(KIND_READY, 8'h00, 1'b0, 1'b0, 1);
      queue_word(KIND_READY, 8'h00, 1'b0, 1'b1, 0);   // empty and held
      queue_word(KIND_WRITE, 8'hA5, 1'b1, 1'b0, 0);
      queue_word(KIND_WRITE, 8'h5A, 1'b0, 1'b0, 2);
      queue_word(KIND_WRITE, 8'h3C, 1'b1, 1'b1, 0);
      queue_csr(1'b0);
      queue_word(KIND_READY, 8'h00, 1'b0, 1'b1, 0);   // cts ignored now
      queue_word(KIND_READY, 8'hFF, 1'b0, 1'b1, 0);
      queue_word(KIND_READY, 8'h00, 1'b0, 1'b0, 0);
      queue_word(KIND_READY, 8'h00, 1'b0, 1'b1, 0);
      queue_csr(1'b1);

      // flood: mostly writes, enough to fill the ring, wrap the head past
      // zero and keep dropping the oldest byte
      for (int unsigned n = 0; n < 300; n += 8)
         queue_burst(8, 10, 50);

      // flow control off, balanced traffic
      queue_csr(1'b0);
      queue_mix(110, 50);

      // flow control on with cts mostly high; one full drain halfway
      queue_csr(1'b1);
      queue_mix(50, 70);
      queue_settle();
      queue_mix(50, 70);

      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (stim_steps.size() != 0 || drv_state != DRV_FETCH || rsp_owed != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Words taken %0d, csr writes %0d, bytes sent %0d, held by cts %0d",
               items_taken, csr_writes, pops_seen, held_count);
      $display("Oldest byte dropped %0d times, burst overruns reported %0d, mismatches %0d",
               drops_seen, overrun_reports, mismatches);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/txrf_pkg.sv
design/tx_ring_fifo_drop_oldest_cts.sv
design/txrf_checker.sv
tb/sv/tx_ring_fifo_drop_oldest_cts_tb.sv
